@@ design/vst_pkg.sv @@
// Shared constants and codes for the value set table.
package vst_pkg;

    localparam int ACTION_W     = 2;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int FIELD_W      = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_CHANGED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOCHANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

endpackage

@@ design/vst_ifs.sv @@
// Request and response channel interfaces of the value set table.
interface vst_req_if;
    logic                                valid;
    logic                                ready;
    logic [vst_pkg::ACTION_W-1:0]        action;
    logic signed [vst_pkg::VALUE_W-1:0]  value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

interface vst_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [vst_pkg::STATUS_W-1:0]  status;
    logic                          found;
    logic [vst_pkg::FIELD_W-1:0]   position;
    logic [vst_pkg::FIELD_W-1:0]   count;

    modport source (output valid, status, found, position, count, input ready);
    modport sink   (input valid, status, found, position, count, output ready);
endinterface

@@ design/vst_mem.sv @@
// Element store: one write port and one registered read port.
module vst_mem #(
    parameter int DEPTH = vst_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [vst_pkg::VALUE_W-1:0]  o_rd_data,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [vst_pkg::VALUE_W-1:0]  i_wr_data
);
    import vst_pkg::*;

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/vst_ctrl.sv @@
// Sequencer: scans the store, appends, shifts down on delete, holds the response register.
module vst_ctrl #(
    parameter int CAPACITY = vst_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    vst_req_if.sink                      i_req,
    vst_rsp_if.source                    o_rsp,
    output logic                         o_rd_en,
    output logic [AW-1:0]                o_rd_addr,
    input  logic [vst_pkg::VALUE_W-1:0]  i_rd_data,
    output logic                         o_wr_en,
    output logic [AW-1:0]                o_wr_addr,
    output logic [vst_pkg::VALUE_W-1:0]  o_wr_data
);
    import vst_pkg::*;

    localparam int XW = (CW > FIELD_W) ? CW : FIELD_W;

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SHIFT, S_FIN} t_state;

    t_state                r_state, n_state;
    logic [ACTION_W-1:0]   r_act, n_act;
    logic [VALUE_W-1:0]    r_val, n_val;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [CW-1:0]         r_pend_idx, n_pend_idx;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_hit, n_hit;
    logic [CW-1:0]         r_pos, n_pos;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic                  r_out_found, n_out_found;
    logic [FIELD_W-1:0]    r_out_pos, n_out_pos;
    logic [FIELD_W-1:0]    r_out_cnt, n_out_cnt;

    logic                  w_rd_issue;
    logic                  w_match;
    logic                  w_last;
    logic [CW-1:0]         w_shift_dst;
    logic [XW-1:0]         w_pos_x;
    logic [XW-1:0]         w_cnt_x;

    assign w_rd_issue  = ((r_state == S_SEARCH) || (r_state == S_SHIFT)) && (r_idx < r_count);
    assign w_match     = r_pend && (i_rd_data == r_val);
    assign w_last      = r_pend && ((r_pend_idx + CW'(1)) == r_count);
    assign w_shift_dst = r_pend_idx - CW'(1);
    assign w_pos_x     = XW'(r_pos);
    assign w_cnt_x     = XW'(r_count);

    assign o_rd_en   = w_rd_issue;
    assign o_rd_addr = r_idx[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_act        = r_act;
        n_val        = r_val;
        n_idx        = r_idx;
        n_pend       = 1'b0;
        n_pend_idx   = r_idx;
        n_count      = r_count;
        n_hit        = r_hit;
        n_pos        = r_pos;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_pos    = r_out_pos;
        n_out_cnt    = r_out_cnt;
        o_wr_en      = 1'b0;
        o_wr_addr    = w_shift_dst[AW-1:0];
        o_wr_data    = i_rd_data;

        if (w_rd_issue) begin
            n_idx  = r_idx + CW'(1);
            n_pend = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_act   = i_req.action;
                    n_val   = i_req.value;
                    n_idx   = '0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_match) begin
                    n_hit = 1'b1;
                    n_pos = r_pend_idx;
                    if (r_act == ACT_DELETE) begin
                        n_status = ST_CHANGED;
                        n_pend   = 1'b0;
                        if (w_last) begin
                            n_count = r_count - CW'(1);
                            n_state = S_FIN;
                        end else begin
                            n_idx   = r_pend_idx + CW'(1);
                            n_state = S_SHIFT;
                        end
                    end else begin
                        n_status = ST_NOCHANGE;
                        n_state  = S_FIN;
                    end
                end else if ((r_count == '0) || w_last) begin
                    n_hit    = 1'b0;
                    n_pos    = r_count;
                    n_status = ST_NOCHANGE;
                    n_state  = S_FIN;
                    if (r_act == ACT_INSERT) begin
                        if (r_count < CW'(CAPACITY)) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_count[AW-1:0];
                            o_wr_data = r_val;
                            n_count   = r_count + CW'(1);
                            n_status  = ST_CHANGED;
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    o_wr_en = 1'b1;
                end
                if (w_last) begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_hit;
                    n_out_pos    = w_pos_x[FIELD_W-1:0];
                    n_out_cnt    = w_cnt_x[FIELD_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_act        <= n_act;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_pend_idx   <= n_pend_idx;
        r_hit        <= n_hit;
        r_pos        <= n_pos;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_pos    <= n_out_pos;
        r_out_cnt    <= n_out_cnt;
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.found    = r_out_found;
    assign o_rsp.position = r_out_pos;
    assign o_rsp.count    = r_out_cnt;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("Element count exceeds capacity.");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (CW'(o_wr_addr) <= r_count))
        else $error("Store write lands beyond the end of the table.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1))))
        else $error("Element count moved by more than one.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("Request accepted while a transaction is still in progress.");

    a_shift_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_hit && (r_act == ACT_DELETE)))
        else $error("Shift running without a matched delete.");
`endif

endmodule

@@ design/value_set_table_core.sv @@
// Top level of the value set table: sequencer plus element store.
//
// The block keeps up to CAPACITY distinct 32-bit values and serves one
// transaction at a time. A request scans the store from entry 0 at one entry
// per cycle through the single read port; a delete that hits entry pos then
// moves the later entries down. The response sits in an output register, so
// the next request is taken while a response still waits. Position and count
// carry their low five bits. The store needs no clearing after reset.
module value_set_table_core #(
    parameter int CAPACITY = vst_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vst_req_if.sink     i_req,
    vst_rsp_if.source   o_rsp
);
    import vst_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [VALUE_W-1:0]  rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [VALUE_W-1:0]  wr_data;

    vst_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    vst_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for value_set_table_core: directed table, then random traffic.
module tb_top;
    import vst_pkg::*;

    localparam int TBL_CAP     = CAPACITY_DEF;
    localparam int RAND_ITEMS  = 1700;
    localparam int QUIET_ITEMS = 150;
    localparam int POOL_N      = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 64;

    // The action code that the block does not define behaves as a query.
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [FIELD_W-1:0]  position;
        logic [FIELD_W-1:0]  count;
    } t_vst_rsp;

    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [VALUE_W-1:0]  val;
        bit                  typed;
        t_vst_rsp            rsp;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    vst_req_if req_ch ();
    vst_rsp_if rsp_ch ();

    value_set_table_core #(
        .CAPACITY (TBL_CAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic [VALUE_W-1:0] set_vals [TBL_CAP];
    int                 set_n;
    t_vst_rsp           pending [$];
    logic [VALUE_W-1:0] value_pool [POOL_N];

    int n_err;
    int n_req;
    int n_rsp;
    int n_full_rej;
    int n_shift_del;
    int n_emptied;
    int n_filled;
    int cycles;
    bit quiet;
    bit sender_idles;

    t_dir_row dir_tab [27] = '{
        '{ACT_QUERY,  32'h0000_0000, 1'b1, '{ST_NOCHANGE, 1'b0, 5'd0,  5'd0}},
        '{ACT_DELETE, 32'h0000_0005, 1'b1, '{ST_NOCHANGE, 1'b0, 5'd0,  5'd0}},
        '{ACT_INSERT, 32'h8000_0000, 1'b1, '{ST_CHANGED,  1'b0, 5'd0,  5'd1}},
        '{ACT_INSERT, 32'h7FFF_FFFF, 1'b1, '{ST_CHANGED,  1'b0, 5'd1,  5'd2}},
        '{ACT_INSERT, 32'h8000_0000, 1'b1, '{ST_NOCHANGE, 1'b1, 5'd0,  5'd2}},
        '{ACT_SPARE,  32'h7FFF_FFFF, 1'b1, '{ST_NOCHANGE, 1'b1, 5'd1,  5'd2}},
        '{ACT_DELETE, 32'h8000_0000, 1'b1, '{ST_CHANGED,  1'b1, 5'd0,  5'd1}},
        '{ACT_QUERY,  32'h8000_0000, 1'b1, '{ST_NOCHANGE, 1'b0, 5'd1,  5'd1}},
        '{ACT_INSERT, 32'h0000_0001, 1'b1, '{ST_CHANGED,  1'b0, 5'd1,  5'd2}},
        '{ACT_INSERT, 32'hFFFF_FFFE, 1'b1, '{ST_CHANGED,  1'b0, 5'd2,  5'd3}},
        '{ACT_INSERT, 32'h5555_5555, 1'b1, '{ST_CHANGED,  1'b0, 5'd3,  5'd4}},
        '{ACT_INSERT, 32'hAAAA_AAAA, 1'b1, '{ST_CHANGED,  1'b0, 5'd4,  5'd5}},
        '{ACT_INSERT, 32'h0000_0000, 1'b1, '{ST_CHANGED,  1'b0, 5'd5,  5'd6}},
        '{ACT_INSERT, 32'hFFFF_FFFF, 1'b1, '{ST_CHANGED,  1'b0, 5'd6,  5'd7}},
        '{ACT_INSERT, 32'h8000_0001, 1'b1, '{ST_CHANGED,  1'b0, 5'd7,  5'd8}},
        '{ACT_INSERT, 32'h7FFF_FFFE, 1'b1, '{ST_CHANGED,  1'b0, 5'd8,  5'd9}},
        '{ACT_INSERT, 32'h0000_FFFF, 1'b1, '{ST_CHANGED,  1'b0, 5'd9,  5'd10}},
        '{ACT_INSERT, 32'hFFFF_0000, 1'b1, '{ST_CHANGED,  1'b0, 5'd10, 5'd11}},
        '{ACT_INSERT, 32'h1234_5678, 1'b1, '{ST_CHANGED,  1'b0, 5'd11, 5'd12}},
        '{ACT_INSERT, 32'hEDCB_A987, 1'b1, '{ST_CHANGED,  1'b0, 5'd12, 5'd13}},
        '{ACT_INSERT, 32'h0F0F_0F0F, 1'b1, '{ST_CHANGED,  1'b0, 5'd13, 5'd14}},
        '{ACT_INSERT, 32'hF0F0_F0F0, 1'b1, '{ST_CHANGED,  1'b0, 5'd14, 5'd15}},
        '{ACT_INSERT, 32'h0000_0100, 1'b1, '{ST_CHANGED,  1'b0, 5'd15, 5'd16}},
        '{ACT_INSERT, 32'h8000_0000, 1'b1, '{ST_FULL,     1'b0, 5'd16, 5'd16}},
        '{ACT_DELETE, 32'h5555_5555, 1'b0, '0},
        '{ACT_INSERT, 32'h8000_0000, 1'b0, '0},
        '{ACT_QUERY,  32'hAAAA_AAAA, 1'b0, '0}
    };

    function automatic t_vst_rsp predict_response(input logic [ACTION_W-1:0] act,
                                                  input logic [VALUE_W-1:0] val);
        t_vst_rsp r;
        int       hit_at;
        int       old_n;
        bit       hit;
        int       i;
        old_n  = set_n;
        hit_at = set_n;
        for (i = set_n - 1; i >= 0; i--) begin
            if (set_vals[i] == val) begin
                hit_at = i;
            end
        end
        hit      = (hit_at < old_n);
        r.status = ST_NOCHANGE;
        if (act == ACT_INSERT && !hit) begin
            if (old_n < TBL_CAP) begin
                set_vals[old_n] = val;
                set_n           = old_n + 1;
                r.status        = ST_CHANGED;
                if (set_n == TBL_CAP) begin
                    n_filled++;
                end
            end else begin
                r.status = ST_FULL;
                n_full_rej++;
            end
        end else if (act == ACT_DELETE && hit) begin
            if (hit_at + 1 < old_n) begin
                n_shift_del++;
            end
            for (i = hit_at; i + 1 < old_n; i++) begin
                set_vals[i] = set_vals[i + 1];
            end
            set_n    = old_n - 1;
            r.status = ST_CHANGED;
            if (set_n == 0) begin
                n_emptied++;
            end
        end
        r.found    = hit;
        r.position = hit_at[FIELD_W-1:0];
        r.count    = set_n[FIELD_W-1:0];
        return r;
    endfunction

    task automatic issue_request(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                                 input bit typed, input t_vst_rsp typed_rsp);
        t_vst_rsp model_rsp;
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= val;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        model_rsp = predict_response(act, val);
        pending.push_back(typed ? typed_rsp : model_rsp);
        n_req++;
        if (!quiet && sender_idles && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (pending.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin : rsp_ready_gen
        rsp_ch.ready <= 1'b0;
        repeat (7) @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_vst_rsp want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            n_rsp++;
            if (pending.size() == 0) begin
                $error("unexpected response: status %0d found %0d position %0d count %0d",
                       rsp_ch.status, rsp_ch.found, rsp_ch.position, rsp_ch.count);
                n_err++;
            end else begin
                want = pending.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    n_err++;
                end
                if (rsp_ch.found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, rsp_ch.found);
                    n_err++;
                end
                if (rsp_ch.position !== want.position) begin
                    $error("position: expected %0d, actual %0d", want.position,
                           rsp_ch.position);
                    n_err++;
                end
                if (rsp_ch.count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, rsp_ch.count);
                    n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : main_seq
        int                  k;
        int                  roll;
        int                  ins_cut;
        int                  del_cut;
        logic [ACTION_W-1:0] act;
        logic [VALUE_W-1:0]  val;

        req_ch.valid  <= 1'b0;
        req_ch.action <= ACT_QUERY;
        req_ch.value  <= '0;
        set_n        = 0;
        quiet        = 1'b0;
        sender_idles = 1'b1;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (k = 4; k < POOL_N; k++) begin
            value_pool[k] = $urandom;
        end

        repeat (8) @(posedge i_clk);

        for (k = 0; k < $size(dir_tab); k++) begin
            issue_request(dir_tab[k].act, dir_tab[k].val, dir_tab[k].typed, dir_tab[k].rsp);
        end
        drain_responses();

        for (k = 0; k < RAND_ITEMS; k++) begin
            if (k % 100 == 0) begin
                sender_idles = ($urandom_range(0, 3) != 0);
            end
            if (k == RAND_ITEMS - QUIET_ITEMS) begin
                quiet = 1'b1;
            end
            if ((k / 100) % 2 == 0) begin
                ins_cut = 55;
                del_cut = 75;
            end else begin
                ins_cut = 20;
                del_cut = 70;
            end
            roll = $urandom_range(0, 99);
            if (roll < ins_cut) begin
                act = ACT_INSERT;
            end else if (roll < del_cut) begin
                act = ACT_DELETE;
            end else if (roll < 95) begin
                act = ACT_QUERY;
            end else begin
                act = ACT_SPARE;
            end
            roll = $urandom_range(0, 99);
            if (roll < 85 && set_n > 0 && roll >= 60) begin
                val = set_vals[$urandom_range(0, set_n - 1)];
            end else if (roll < 85) begin
                val = value_pool[$urandom_range(0, POOL_N - 1)];
            end else begin
                val = $urandom;
            end
            issue_request(act, val, 1'b0, '0);
            if (k % 400 == 399) begin
                drain_responses();
            end
        end
        drain_responses();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests and %0d responses, %0d inserts refused when full.",
                 n_req, n_rsp, n_full_rej);
        $display("The table filled %0d times and emptied %0d times; %0d deletes moved entries.",
                 n_filled, n_emptied, n_shift_del);
        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
